@@ sv/fsp_pkg.sv @@
// Shared types, opcodes and constants of the five-stage pipeline subset.
// Used by fsp_regfile, fsp_dmem and five_stage_pipeline_subset.
package fsp_pkg;

    localparam int REG_ADDR_W = 5;

    // Opcode and function codes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_SUB   = 6'h22;

    // Register file contents after reset: base plus index, zero for register 0
    localparam logic [31:0] REG_INIT_BASE = 32'h0000_0100;

    // ID/EX bundle
    typedef struct packed {
        logic                  reg_write;
        logic                  mem_read;
        logic                  mem_write;
        logic                  alu_sub;
        logic                  alu_imm;
        logic [31:0]           rs_val;
        logic [31:0]           rt_val;
        logic [31:0]           imm;
        logic [REG_ADDR_W-1:0] dest;
    } de_bundle_t;

    // EX/MEM bundle
    typedef struct packed {
        logic                  reg_write;
        logic                  mem_read;
        logic                  mem_write;
        logic [31:0]           alu;
        logic [7:0]            store_byte;
        logic [REG_ADDR_W-1:0] dest;
    } em_bundle_t;

    // MEM/WB bundle
    typedef struct packed {
        logic                  reg_write;
        logic [31:0]           value;
        logic [REG_ADDR_W-1:0] dest;
    } mw_bundle_t;

    // Register file request: two reads and one write per tick
    typedef struct packed {
        logic                  rd_en;
        logic [REG_ADDR_W-1:0] rd_addr_a;
        logic [REG_ADDR_W-1:0] rd_addr_b;
        logic                  wr_en;
        logic [REG_ADDR_W-1:0] wr_addr;
        logic [31:0]           wr_data;
    } rf_req_t;

    // Data memory request: full ALU result as address, memory keeps low bits
    typedef struct packed {
        logic        rd_en;
        logic [31:0] rd_addr;
        logic        wr_en;
        logic [31:0] wr_addr;
        logic [7:0]  wr_data;
    } dm_req_t;

    function automatic logic [31:0] reg_init_value(input logic [REG_ADDR_W-1:0] idx);
        logic [31:0] v;
        v = (idx == '0) ? 32'h0 : (REG_INIT_BASE + {{(32-REG_ADDR_W){1'b0}}, idx});
        return v;
    endfunction

endpackage

@@ sv/fsp_regfile.sv @@
// Register file: 32 x 32 synchronous memory, two read ports, one write port.
// Valid bits stand in for the reset contents; same-edge writes are forwarded.
// Depends on fsp_pkg.
module fsp_regfile (
    input  logic             clk,
    input  logic             rst_n,
    input  fsp_pkg::rf_req_t req,
    output logic [31:0]      rd_data_a,
    output logic [31:0]      rd_data_b
);
    import fsp_pkg::*;

    localparam int DEPTH = 1 << REG_ADDR_W;

    logic [31:0]           mem [DEPTH];
    logic [31:0]           rdata_a_reg;
    logic [31:0]           rdata_b_reg;
    logic [31:0]           fwd_data_reg;
    logic [REG_ADDR_W-1:0] addr_a_reg;
    logic [REG_ADDR_W-1:0] addr_b_reg;
    logic [DEPTH-1:0]      valid_reg;
    logic                  fwd_a_reg;
    logic                  fwd_b_reg;
    logic                  vld_a_reg;
    logic                  vld_b_reg;
    logic                  wr_ok;

    // Register 0 is never written
    assign wr_ok = req.wr_en && (req.wr_addr != '0);

    // Memory array: write port and registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_a_reg  <= mem[req.rd_addr_a];
            rdata_b_reg  <= mem[req.rd_addr_b];
            addr_a_reg   <= req.rd_addr_a;
            addr_b_reg   <= req.rd_addr_b;
            fwd_data_reg <= req.wr_data;
        end
    end

    // Track written entries and capture forwarding selects
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                fwd_a_reg <= wr_ok && (req.wr_addr == req.rd_addr_a);
                fwd_b_reg <= wr_ok && (req.wr_addr == req.rd_addr_b);
                vld_a_reg <= valid_reg[req.rd_addr_a];
                vld_b_reg <= valid_reg[req.rd_addr_b];
            end
        end
    end

    // Select forwarded, stored or reset contents
    always_comb
    begin
        if (fwd_a_reg)
            rd_data_a = fwd_data_reg;
        else if (vld_a_reg)
            rd_data_a = rdata_a_reg;
        else
            rd_data_a = reg_init_value(addr_a_reg);

        if (fwd_b_reg)
            rd_data_b = fwd_data_reg;
        else if (vld_b_reg)
            rd_data_b = rdata_b_reg;
        else
            rd_data_b = reg_init_value(addr_b_reg);
    end

endmodule

@@ sv/fsp_dmem.sv @@
// Byte-wide data memory with a registered read port and a clearing pass
// that loads each entry with the low byte of its address. Depends on fsp_pkg.
module fsp_dmem #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fsp_pkg::dm_req_t req,
    output logic [7:0]       rd_data,
    output logic             ready
);
    import fsp_pkg::*;

    localparam int ADDR_W = $clog2(MEM_DEPTH);

    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        rdata_reg;
    logic [7:0]        fwd_data_reg;
    logic              fwd_reg;
    logic              busy_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_hit;

    assign rd_addr = req.rd_addr[ADDR_W-1:0];
    assign wr_addr = req.wr_addr[ADDR_W-1:0];
    assign wr_hit  = req.wr_en && (wr_addr == rd_addr);
    assign ready   = !busy_reg;

    // Memory array: clearing sweep or store, registered read
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[cnt_reg] <= 8'(cnt_reg);
        end
        else if (req.wr_en)
        begin
            mem[wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= req.wr_data;
        end
    end

    // Clearing sweep control and forward select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            fwd_reg  <= 1'b0;
        end
        else
        begin
            if (busy_reg)
            begin
                if (cnt_reg == ADDR_W'(MEM_DEPTH - 1))
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (req.rd_en)
            begin
                fwd_reg <= wr_hit;
            end
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rdata_reg;

endmodule

@@ sv/five_stage_pipeline_subset.sv @@
// Top level of the five-stage pipeline subset (IF, ID, EX, MEM, WB).
// Instantiates fsp_regfile and fsp_dmem; depends on fsp_pkg.
//
// Usage:
//   Slave channel s_t*: one 32-bit instruction word per request; zero is a nop.
//   Master channel m_t*: one result per accepted instruction, reporting the
//   write-back and the byte store of that pipeline tick.
//   Every accepted request advances the pipeline by one tick; nothing moves
//   between requests. The result of a tick is registered and shows on m_t*
//   in the cycle after the request is accepted.
//   Throughput: one instruction per cycle unless stalled, as the stage logic is
//   combinational and the reads of the register file and data memory are
//   registered and issued on the tick before the stage that uses them.
//   An instruction's write-back is reported with the fourth request after it.
//   Reset: pipeline bundles clear to nops, the register file reads 0x100 plus
//   its index (0 for register 0), and the data memory is swept to the low
//   byte of each address; s_tready stays low meanwhile.
//   Stall: while a result waits with m_tready low, s_tready is low and the
//   pipeline holds; a result taken in the same cycle frees the slot at once.
//   MEM_DEPTH must be a power of two.
module five_stage_pipeline_subset #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] instr
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [0] wb_enable, [5:1] wb_reg, [37:6] wb_value,
                                   // [38] store_enable, [48:39] store_addr,
                                   // [56:49] store_data, [63:57] zero
);
    import fsp_pkg::*;

    localparam int ADDR_W = $clog2(MEM_DEPTH);

    logic [31:0] fd_word_reg;
    de_bundle_t  de_reg;
    de_bundle_t  de_next;
    em_bundle_t  em_reg;
    em_bundle_t  em_next;
    mw_bundle_t  mw_reg;
    mw_bundle_t  mw_next;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;

    rf_req_t     rf_req;
    dm_req_t     dm_req;
    logic [31:0] rf_rd_a;
    logic [31:0] rf_rd_b;
    logic [7:0]  dm_rd_data;
    logic        dm_ready;
    logic        accept;

    logic [5:0]            op;
    logic [5:0]            fn;
    logic                  wb_enable;
    logic [REG_ADDR_W-1:0] wb_reg;
    logic [31:0]           wb_value;
    logic                  store_enable;
    logic [9:0]            store_addr;
    logic [7:0]            store_data;

    // Handshake: a tick runs on every accepted request
    assign s_tready = dm_ready && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ID: decode the fetched word with register data read on the previous tick
    assign op = fd_word_reg[31:26];
    assign fn = fd_word_reg[5:0];

    always_comb
    begin
        de_next = '0;
        priority if (op == OP_LB || op == OP_SB)
        begin
            de_next.mem_read  = (op == OP_LB);
            de_next.mem_write = (op == OP_SB);
            de_next.reg_write = (op == OP_LB);
            de_next.alu_imm   = 1'b1;
            de_next.dest      = fd_word_reg[20:16];
            de_next.rs_val    = rf_rd_a;
            de_next.rt_val    = rf_rd_b;
            de_next.imm       = {{16{fd_word_reg[15]}}, fd_word_reg[15:0]};
        end
        else if (op == OP_RTYPE && (fn == FN_ADD || fn == FN_SUB))
        begin
            de_next.reg_write = 1'b1;
            de_next.alu_sub   = (fn == FN_SUB);
            de_next.dest      = fd_word_reg[15:11];
            de_next.rs_val    = rf_rd_a;
            de_next.rt_val    = rf_rd_b;
            de_next.imm       = {{16{fd_word_reg[15]}}, fd_word_reg[15:0]};
        end
        else
        begin
            de_next = '0;
        end
    end

    // EX: add or subtract
    always_comb
    begin
        em_next = '0;
        if (de_reg.reg_write || de_reg.mem_read || de_reg.mem_write)
        begin
            em_next.reg_write  = de_reg.reg_write;
            em_next.mem_read   = de_reg.mem_read;
            em_next.mem_write  = de_reg.mem_write;
            em_next.store_byte = de_reg.rt_val[7:0];
            em_next.dest       = de_reg.dest;
            if (de_reg.alu_sub)
                em_next.alu = de_reg.rs_val - de_reg.rt_val;
            else
                em_next.alu = de_reg.rs_val + (de_reg.alu_imm ? de_reg.imm : de_reg.rt_val);
        end
    end

    // MEM: pick loaded byte or ALU result
    always_comb
    begin
        mw_next.reg_write = em_reg.reg_write;
        mw_next.dest      = em_reg.dest;
        mw_next.value     = em_reg.mem_read ? {24'h0, dm_rd_data} : em_reg.alu;
    end

    // Memory requests: read ahead for the next tick, write this tick's store
    always_comb
    begin
        rf_req.rd_en     = accept;
        rf_req.rd_addr_a = s_tdata[25:21];
        rf_req.rd_addr_b = s_tdata[20:16];
        rf_req.wr_en     = accept && wb_enable;
        rf_req.wr_addr   = mw_reg.dest;
        rf_req.wr_data   = mw_reg.value;

        dm_req.rd_en     = accept;
        dm_req.rd_addr   = em_next.alu;
        dm_req.wr_en     = accept && em_reg.mem_write;
        dm_req.wr_addr   = em_reg.alu;
        dm_req.wr_data   = em_reg.store_byte;
    end

    // Result of this tick
    always_comb
    begin
        wb_enable    = mw_reg.reg_write && (mw_reg.dest != '0);
        wb_reg       = wb_enable ? mw_reg.dest : '0;
        wb_value     = wb_enable ? mw_reg.value : 32'h0;
        store_enable = em_reg.mem_write;
        store_addr   = store_enable ? 10'(em_reg.alu[ADDR_W-1:0]) : 10'h0;
        store_data   = store_enable ? em_reg.store_byte : 8'h0;
        out_data_next = {7'h0, store_data, store_addr, store_enable,
                         wb_value, wb_reg, wb_enable};
    end

    // Advance pipeline registers on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fd_word_reg <= '0;
            de_reg      <= '0;
            em_reg      <= '0;
            mw_reg      <= '0;
        end
        else if (accept)
        begin
            fd_word_reg <= s_tdata;
            de_reg      <= de_next;
            em_reg      <= em_next;
            mw_reg      <= mw_next;
        end
    end

    // Output slot: load on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    fsp_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (rf_req),
        .rd_data_a (rf_rd_a),
        .rd_data_b (rf_rd_b)
    );

    fsp_dmem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (dm_req),
        .rd_data (dm_rd_data),
        .ready   (dm_ready)
    );

`ifndef SYNTHESIS
    // Every accepted request leaves a result in the output slot
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("no result after accepted request");

    // Register writes happen only on a tick and never to register 0
    a_rf_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_req.wr_en |-> (accept && rf_req.wr_addr != '0))
        else $error("register write outside a tick or to register 0");

    // No request is taken while the data memory sweep runs
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !dm_ready |-> !accept && !dm_req.wr_en)
        else $error("request or store during data memory sweep");
`endif

endmodule

@@ tb/five_stage_pipeline_subset_test.sv @@
// Self-checking testbench for five_stage_pipeline_subset: a directed table,
// then random instruction streams under varying stream pressure.
// Depends on fsp_pkg and the five_stage_pipeline_subset RTL.
`timescale 1ns / 1ps

module five_stage_pipeline_subset_test;

    import fsp_pkg::*;

    localparam int MEM_DEPTH     = 1024;
    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 6;
    localparam int PHASE_ITEMS   = 230;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_NS      = 200000 * CLK_PERIOD;

    // One pipeline tick's report, laid out as m_tdata (first member is the MSB)
    typedef struct packed {
        logic [6:0]  pad;
        logic [7:0]  st_data;
        logic [9:0]  st_addr;
        logic        st_en;
        logic [31:0] wb_value;
        logic [4:0]  wb_reg;
        logic        wb_en;
    } tick_result_t;

    typedef struct packed {
        logic        reg_write;
        logic        mem_read;
        logic        mem_write;
        logic        do_sub;
        logic        use_imm;
        logic [31:0] rs_val;
        logic [31:0] rt_val;
        logic [31:0] imm;
        logic [4:0]  dest;
    } id_ex_t;

    typedef struct packed {
        logic        reg_write;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] alu;
        logic [7:0]  store_byte;
        logic [4:0]  dest;
    } ex_mem_t;

    typedef struct packed {
        logic        reg_write;
        logic [31:0] value;
        logic [4:0]  dest;
    } mem_wb_t;

    typedef struct {
        logic [31:0]  word;
        bit           typed;
        tick_result_t res;
    } stim_row_t;

    localparam tick_result_t RES_IDLE = '0;
    // add r3 written back (0x101 + 0x102) together with sb of r5 to 0x7FFF mod depth
    localparam tick_result_t RES_FIRST = '{7'd0, 8'h05, 10'h3FF, 1'b1, 32'h0000_0203,
                                           5'd3, 1'b1};

    // Directed requests; only the first ticks after reset carry a typed result
    stim_row_t dir_table [22] = '{
        '{32'h0022_1820, 1'b1, RES_IDLE},   // add r3, r1, r2
        '{32'hA005_7FFF, 1'b1, RES_IDLE},   // sb r5, 0x7FFF(r0)
        '{32'h0000_0000, 1'b1, RES_IDLE},   // zero word
        '{32'hFFFF_FFFF, 1'b1, RES_IDLE},   // all ones: unknown opcode
        '{32'h8007_FFFF, 1'b1, RES_FIRST},  // lb r7, -1(r0): wraps onto the byte just stored
        '{32'h0022_1822, 1'b0, RES_IDLE},   // sub r3, r1, r2: negative result
        '{32'h0022_0020, 1'b0, RES_IDLE},   // add into r0: discarded
        '{32'h0022_1821, 1'b0, RES_IDLE},   // R-type with unknown funct
        '{32'h03FF_F820, 1'b0, RES_IDLE},   // add r31, r31, r31
        '{32'h0000_0000, 1'b0, RES_IDLE},
        '{32'h0085_2020, 1'b0, RES_IDLE},   // add r4, r4, r5
        '{32'h0084_2020, 1'b0, RES_IDLE},   // add r4, r4, r4: reads stale r4
        '{32'hA3FF_8000, 1'b0, RES_IDLE},   // sb r31, -32768(r31)
        '{32'h83E9_0010, 1'b0, RES_IDLE},   // lb r9, 16(r31)
        '{32'hA0E0_0000, 1'b0, RES_IDLE},   // sb r0, 0(r7)
        '{32'h8C00_0000, 1'b0, RES_IDLE},   // lw opcode: not decoded
        '{32'hFC00_0020, 1'b0, RES_IDLE},   // opcode all ones with add funct
        '{32'h0000_FFE0, 1'b0, RES_IDLE},   // add r31, r0, r0 with shamt set
        '{32'h8001_0000, 1'b0, RES_IDLE},   // lb r1, 0(r0)
        '{32'h0000_0000, 1'b0, RES_IDLE},
        '{32'h0000_0000, 1'b0, RES_IDLE},
        '{32'h0000_0000, 1'b0, RES_IDLE}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    // Predictor state
    logic [31:0] if_id_word;
    id_ex_t      id_ex;
    ex_mem_t     ex_mem;
    mem_wb_t     mem_wb;
    logic [31:0] gpr [32];
    logic [7:0]  dmem [MEM_DEPTH];

    tick_result_t expected_results [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_left    = 0;
    int err_count    = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int wb_seen      = 0;
    int st_seen      = 0;

    five_stage_pipeline_subset #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    // Advance the predicted pipeline by one tick and return that tick's report
    function automatic tick_result_t pipe_tick(input logic [31:0] w);
        id_ex_t       nd;
        ex_mem_t      ne;
        mem_wb_t      nm;
        tick_result_t r;
        logic [5:0]   op;
        logic [5:0]   fn;
        logic [4:0]   rs;
        logic [4:0]   rt;
        logic [4:0]   rd;
        logic [31:0]  addr;
        op = if_id_word[31:26];
        fn = if_id_word[5:0];
        rs = if_id_word[25:21];
        rt = if_id_word[20:16];
        rd = if_id_word[15:11];
        nd = '0;
        // Decode the fetched word: register reads happen before this tick's write-back
        if (op == OP_LB || op == OP_SB)
        begin
            nd.mem_read  = (op == OP_LB);
            nd.mem_write = (op == OP_SB);
            nd.reg_write = (op == OP_LB);
            nd.use_imm   = 1'b1;
            nd.dest      = rt;
        end
        else if (op == OP_RTYPE && (fn == FN_ADD || fn == FN_SUB))
        begin
            nd.reg_write = 1'b1;
            nd.do_sub    = (fn == FN_SUB);
            nd.dest      = rd;
        end
        if (nd.reg_write || nd.mem_write)
        begin
            nd.rs_val = gpr[rs];
            nd.rt_val = gpr[rt];
            nd.imm    = {{16{if_id_word[15]}}, if_id_word[15:0]};
        end

        // Execute
        ne = '0;
        if (id_ex.reg_write || id_ex.mem_read || id_ex.mem_write)
        begin
            ne.reg_write  = id_ex.reg_write;
            ne.mem_read   = id_ex.mem_read;
            ne.mem_write  = id_ex.mem_write;
            if (id_ex.do_sub)
                ne.alu = id_ex.rs_val - id_ex.rt_val;
            else
                ne.alu = id_ex.rs_val + (id_ex.use_imm ? id_ex.imm : id_ex.rt_val);
            ne.store_byte = id_ex.rt_val[7:0];
            ne.dest       = id_ex.dest;
        end

        // Memory: address wraps to the depth
        r = '0;
        addr = ex_mem.alu % MEM_DEPTH;
        nm.reg_write = ex_mem.reg_write;
        nm.dest      = ex_mem.dest;
        nm.value     = ex_mem.mem_read ? {24'h0, dmem[addr]} : ex_mem.alu;
        if (ex_mem.mem_write)
        begin
            dmem[addr] = ex_mem.store_byte;
            r.st_en    = 1'b1;
            r.st_addr  = addr[9:0];
            r.st_data  = ex_mem.store_byte;
        end

        // Write-back: drop writes to register zero
        if (mem_wb.reg_write && mem_wb.dest != 5'd0)
        begin
            gpr[mem_wb.dest] = mem_wb.value;
            r.wb_en    = 1'b1;
            r.wb_reg   = mem_wb.dest;
            r.wb_value = mem_wb.value;
        end

        if_id_word = w;
        id_ex      = nd;
        ex_mem     = ne;
        mem_wb     = nm;
        return r;
    endfunction

    // Favor a few low registers so that back-to-back dependencies are common
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
    endfunction

    // Mostly well-formed add, sub, lb, sb; the rest nops and noise words
    function automatic logic [31:0] next_instr();
        int unsigned pick;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [15:0] off;
        pick = $urandom_range(99);
        rs   = pick_reg();
        rt   = pick_reg();
        rd   = pick_reg();
        off  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(31));
        if (pick < 25)
            return {OP_RTYPE, rs, rt, rd, 5'($urandom), FN_ADD};
        else if (pick < 45)
            return {OP_RTYPE, rs, rt, rd, 5'($urandom), FN_SUB};
        else if (pick < 68)
            return {OP_LB, rs, rt, off};
        else if (pick < 88)
            return {OP_SB, rs, rt, off};
        else if (pick < 92)
            return 32'h0;
        else if (pick < 96)
            return $urandom;
        else
            return {OP_RTYPE, rs, rt, rd, 5'($urandom), 6'($urandom)};
    endfunction

    // Offer one instruction request; record its expected report once accepted
    task automatic send_instr(input logic [31:0] w, input bit typed,
                              input tick_result_t typed_res);
        tick_result_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
        r = pipe_tick(w);
        expected_results.push_back(typed ? typed_res : r);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold the sender off until every outstanding report has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Receiver: random back-pressure, or a counted hold-off when requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Compare each accepted report with the oldest expectation
    always @(posedge clk)
    begin
        tick_result_t want;
        tick_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = tick_result_t'(m_tdata);
            if (expected_results.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected report, expected none actual %h", $time, m_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                results_seen++;
                if (got.wb_en === 1'b1)
                    wb_seen++;
                if (got.st_en === 1'b1)
                    st_seen++;
                check_field("wb_enable", 32'(want.wb_en), 32'(got.wb_en));
                check_field("wb_reg", 32'(want.wb_reg), 32'(got.wb_reg));
                check_field("wb_value", want.wb_value, got.wb_value);
                check_field("store_enable", 32'(want.st_en), 32'(got.st_en));
                check_field("store_addr", 32'(want.st_addr), 32'(got.st_addr));
                check_field("store_data", 32'(want.st_data), 32'(got.st_data));
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 32'h0;

        // Predictor reset state
        if_id_word = 32'h0;
        id_ex      = '0;
        ex_mem     = '0;
        mem_wb     = '0;
        for (int i = 0; i < 32; i++)
            gpr[i] = (i == 0) ? 32'h0 : REG_INIT_BASE + 32'(i);
        for (int a = 0; a < MEM_DEPTH; a++)
            dmem[a] = 8'(a);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table with light back-pressure
        src_idle_pct = 33;
        snk_idle_pct = 33;
        foreach (dir_table[i])
            send_instr(dir_table[i].word, dir_table[i].typed, dir_table[i].res);
        drain();

        // Random streams: slow receiver, slow sender, then full rate
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct = 33;
                    snk_idle_pct = 88;
                end
                1:
                begin
                    src_idle_pct = 88;
                    snk_idle_pct = 33;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    // long receiver hold-off while the sender keeps offering
                    hold_left    = HOLD_CYCLES;
                end
            endcase
            repeat (PHASE_ITEMS)
                send_instr(next_instr(), 1'b0, RES_IDLE);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d reports never arrived", $time, expected_results.size());
        end

        $display("Run sent %0d instructions and checked %0d reports", items_sent, results_seen);
        $display("(%0d register write-backs, %0d byte stores) under three stall patterns",
                 wb_seen, st_seen);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
sv/fsp_pkg.sv
sv/fsp_regfile.sv
sv/fsp_dmem.sv
sv/five_stage_pipeline_subset.sv
tb/five_stage_pipeline_subset_test.sv
